FILE: rtl/core/ebmc_pkg.sv
// Package: types, codes and reset constants of the encoder and button menu controller.
`timescale 1ns / 1ps
`default_nettype none

package ebmc_pkg;

	// Menu selection codes
	typedef enum logic [2:0] {
		SEL_NONE = 3'd0,
		SEL_TEMP = 3'd1,
		SEL_HUM  = 3'd2,
		SEL_LUX  = 3'd3,
		SEL_MODE = 3'd4
	} sel_t;

	// Mode change events
	typedef enum logic [1:0] {
		MODE_EV_NONE = 2'd0,
		MODE_EV_AUTO = 2'd1,
		MODE_EV_OFF  = 2'd2
	} mode_ev_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_FLOOR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CEILING   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HUM_FLOOR      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HUM_CEILING    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LUX_INCREMENT  = 3'd6;

	// Register reset values
	localparam logic [3:0]  RST_STEP_THRESHOLD = 4'd2;
	localparam logic [15:0] RST_IDLE_LIMIT     = 16'd1800;
	localparam logic [7:0]  RST_TEMP_FLOOR     = 8'd20;
	localparam logic [7:0]  RST_TEMP_CEILING   = 8'd160;
	localparam logic [6:0]  RST_HUM_FLOOR      = 7'd20;
	localparam logic [6:0]  RST_HUM_CEILING    = 7'd95;
	localparam logic [15:0] RST_LUX_INCREMENT  = 16'd100;

	// One poll tick
	typedef struct packed {
		logic               button_level;
		logic signed [31:0] encoder_position;
		logic [7:0]         temp_now;
		logic [6:0]         hum_now;
		logic [15:0]        lux_now;
	} tick_t;

	// One result
	typedef struct packed {
		logic        display_active;
		sel_t        selection;
		logic        adjusting;
		logic        all_off;
		logic        temp_write;
		logic [7:0]  temp_value;
		logic        hum_write;
		logic [6:0]  hum_value;
		logic        lux_write;
		logic [15:0] lux_value;
		mode_ev_t    mode_event;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/core/encoder_button_menu_controller.sv
// Top level: encoder and button menu controller with input and result registers.
//
// Usage:
//   Each poll tick enters on the tick channel (tick_valid, tick_stall, tick). A tick is
//   taken at a clock edge with tick_valid high and tick_stall low. It lands in an input
//   register; from there the press detection, encoder accumulation, menu update and
//   setpoint clamping run in one pass and the result is written to the result
//   register once that register is free, shown on result_valid / result.
//   A tick passes through the input register and then the result register before it
//   shows on result_valid. Throughput: one tick per cycle while result_stall is low,
//   as the state update between the two registers is done in one pass.
//   When the receiver holds result_stall, the result register holds, the input register
//   still takes one more tick, and tick_stall then rises until the result is taken.
//   Configuration writes come on cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready
//   is always high and writes to an index beyond the register list are dropped.
//   Write configuration only while no tick is in flight.
//   Reset (arst_n low) clears both registers' valid flags, puts the menu to sleep with
//   nothing selected in auto mode, the button released, the encoder accumulator and
//   the last position at zero, and loads the default configuration.
`timescale 1ns / 1ps
`default_nettype none

module encoder_button_menu_controller (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                tick_valid,
	output logic                               tick_stall,
	input  ebmc_pkg::tick_t                    tick,
	output logic                               result_valid,
	input  wire                                result_stall,
	output ebmc_pkg::result_t                  result,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [ebmc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [ebmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// Configuration registers
	logic [3:0]  step_threshold_q;
	logic [15:0] idle_limit_q;
	logic [7:0]  temp_floor_q;
	logic [7:0]  temp_ceiling_q;
	logic [6:0]  hum_floor_q;
	logic [6:0]  hum_ceiling_q;
	logic [15:0] lux_increment_q;

	// Menu state
	logic               awake_q;
	ebmc_pkg::sel_t     selected_q;
	logic [15:0]        idle_ticks_q;
	logic               prev_button_q;
	logic signed [31:0] step_accum_q;
	logic [31:0]        last_position_q;
	logic               off_flag_q;

	// Pipeline registers
	logic               tick_valid_s1;
	ebmc_pkg::tick_t    tick_s1;
	logic               result_valid_q;
	ebmc_pkg::result_t  result_q;

	// Next-state and result logic
	logic               advance;
	logic               accept;
	logic [31:0]        diff;
	logic               pressed;
	logic signed [32:0] sum_wide;
	logic signed [31:0] sum_sat;
	logic [3:0]         thr;
	logic signed [31:0] thr32;
	logic               step_up;
	logic               step_dn;
	logic signed [31:0] accum_nx;
	logic               activity;
	logic               awake_nx;
	ebmc_pkg::sel_t     selected_nx;
	logic [15:0]        idle_nx;
	logic [15:0]        idle_inc;
	logic               off_nx;
	logic signed [9:0]  t_sum;
	logic signed [9:0]  t_clamp;
	logic signed [8:0]  h_sum;
	logic signed [8:0]  h_clamp;
	logic signed [17:0] l_sum;
	ebmc_pkg::result_t  result_nx;

	assign advance    = tick_valid_s1 && (!result_valid_q || !result_stall);
	assign tick_stall = tick_valid_s1 && !advance;
	assign accept     = tick_valid && !tick_stall;
	assign cfg_ready  = 1'b1;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_threshold_q <= ebmc_pkg::RST_STEP_THRESHOLD;
			idle_limit_q     <= ebmc_pkg::RST_IDLE_LIMIT;
			temp_floor_q     <= ebmc_pkg::RST_TEMP_FLOOR;
			temp_ceiling_q   <= ebmc_pkg::RST_TEMP_CEILING;
			hum_floor_q      <= ebmc_pkg::RST_HUM_FLOOR;
			hum_ceiling_q    <= ebmc_pkg::RST_HUM_CEILING;
			lux_increment_q  <= ebmc_pkg::RST_LUX_INCREMENT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ebmc_pkg::CFG_STEP_THRESHOLD: step_threshold_q <= cfg_data[3:0];
				ebmc_pkg::CFG_IDLE_LIMIT:     idle_limit_q     <= cfg_data;
				ebmc_pkg::CFG_TEMP_FLOOR:     temp_floor_q     <= cfg_data[7:0];
				ebmc_pkg::CFG_TEMP_CEILING:   temp_ceiling_q   <= cfg_data[7:0];
				ebmc_pkg::CFG_HUM_FLOOR:      hum_floor_q      <= cfg_data[6:0];
				ebmc_pkg::CFG_HUM_CEILING:    hum_ceiling_q    <= cfg_data[6:0];
				ebmc_pkg::CFG_LUX_INCREMENT:  lux_increment_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Encoder accumulation and step detection
	always_comb begin
		diff     = tick_s1.encoder_position - last_position_q;
		pressed  = prev_button_q && !tick_s1.button_level;
		sum_wide = {step_accum_q[31], step_accum_q} + $signed({diff[31], diff});
		if (sum_wide[32] != sum_wide[31]) begin
			sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sum_sat = sum_wide[31:0];
		end
		thr     = (step_threshold_q == 4'd0) ? 4'd1 : step_threshold_q;
		thr32   = $signed({28'd0, thr});
		step_up = sum_sat >= thr32;
		step_dn = !step_up && (sum_sat <= -thr32);
		if (step_up) begin
			accum_nx = sum_sat - thr32;
		end else if (step_dn) begin
			accum_nx = sum_sat + thr32;
		end else begin
			accum_nx = sum_sat;
		end
		activity = pressed || step_up || step_dn;
	end

	// Setpoint candidates with clamping; the floor wins over the ceiling
	always_comb begin
		t_sum = $signed({2'b00, tick_s1.temp_now}) + (step_up ? 10'sd1 : -10'sd1);
		t_clamp = t_sum;
		if (t_clamp > $signed({2'b00, temp_ceiling_q})) t_clamp = $signed({2'b00, temp_ceiling_q});
		if (t_clamp < $signed({2'b00, temp_floor_q}))   t_clamp = $signed({2'b00, temp_floor_q});

		h_sum = $signed({2'b00, tick_s1.hum_now}) + (step_up ? 9'sd1 : -9'sd1);
		h_clamp = h_sum;
		if (h_clamp > $signed({2'b00, hum_ceiling_q})) h_clamp = $signed({2'b00, hum_ceiling_q});
		if (h_clamp < $signed({2'b00, hum_floor_q}))   h_clamp = $signed({2'b00, hum_floor_q});

		if (step_up) begin
			l_sum = $signed({2'b00, tick_s1.lux_now}) + $signed({2'b00, lux_increment_q});
		end else begin
			l_sum = $signed({2'b00, tick_s1.lux_now}) - $signed({2'b00, lux_increment_q});
		end
	end

	// Menu update and result
	always_comb begin
		awake_nx    = awake_q;
		selected_nx = selected_q;
		idle_nx     = idle_ticks_q;
		off_nx      = off_flag_q;
		idle_inc    = idle_ticks_q + 16'd1;
		result_nx   = '0;

		if (!awake_q) begin
			// Wake only; the waking activity does nothing else
			if (activity) begin
				awake_nx    = 1'b1;
				selected_nx = ebmc_pkg::SEL_NONE;
				idle_nx     = 16'd0;
			end
		end else if (activity) begin
			idle_nx = 16'd0;
			if (pressed) begin
				case (selected_q)
					ebmc_pkg::SEL_NONE: selected_nx = ebmc_pkg::SEL_TEMP;
					ebmc_pkg::SEL_TEMP: selected_nx = ebmc_pkg::SEL_HUM;
					ebmc_pkg::SEL_HUM:  selected_nx = ebmc_pkg::SEL_LUX;
					ebmc_pkg::SEL_LUX:  selected_nx = ebmc_pkg::SEL_MODE;
					default:            selected_nx = ebmc_pkg::SEL_NONE;
				endcase
			end else begin
				case (selected_q)
					ebmc_pkg::SEL_TEMP: begin
						result_nx.temp_write = 1'b1;
						result_nx.temp_value = t_clamp[7:0];
					end
					ebmc_pkg::SEL_HUM: begin
						result_nx.hum_write = 1'b1;
						result_nx.hum_value = h_clamp[6:0];
					end
					ebmc_pkg::SEL_LUX: begin
						result_nx.lux_write = 1'b1;
						if (l_sum[17]) begin
							result_nx.lux_value = 16'd0;
						end else if (l_sum[16]) begin
							result_nx.lux_value = 16'hffff;
						end else begin
							result_nx.lux_value = l_sum[15:0];
						end
					end
					ebmc_pkg::SEL_MODE: begin
						if (step_up) begin
							off_nx               = 1'b0;
							result_nx.mode_event = ebmc_pkg::MODE_EV_AUTO;
						end else begin
							off_nx               = 1'b1;
							result_nx.mode_event = ebmc_pkg::MODE_EV_OFF;
						end
					end
					default: ;
				endcase
			end
		end else begin
			// Count quiet ticks and drop back to sleep at the limit
			if (idle_inc >= idle_limit_q) begin
				awake_nx    = 1'b0;
				selected_nx = ebmc_pkg::SEL_NONE;
				idle_nx     = 16'd0;
			end else begin
				idle_nx = idle_inc;
			end
		end

		result_nx.display_active = awake_nx;
		result_nx.selection      = awake_nx ? selected_nx : ebmc_pkg::SEL_NONE;
		result_nx.adjusting      = awake_nx && (selected_nx != ebmc_pkg::SEL_NONE);
		result_nx.all_off        = off_nx;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1 <= 1'b0;
		end else if (accept) begin
			tick_valid_s1 <= 1'b1;
		end else if (advance) begin
			tick_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1 <= tick;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nx;
		end
	end

	// Menu state, advanced once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awake_q         <= 1'b0;
			selected_q      <= ebmc_pkg::SEL_NONE;
			idle_ticks_q    <= 16'd0;
			prev_button_q   <= 1'b1;
			step_accum_q    <= 32'sd0;
			last_position_q <= 32'd0;
			off_flag_q      <= 1'b0;
		end else if (advance) begin
			awake_q         <= awake_nx;
			selected_q      <= selected_nx;
			idle_ticks_q    <= idle_nx;
			prev_button_q   <= tick_s1.button_level;
			step_accum_q    <= accum_nx;
			last_position_q <= tick_s1.encoder_position;
			off_flag_q      <= off_nx;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ebmc_checker.sv
// Checker: port-level assertions of the menu controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ebmc_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               result_valid,
	input wire               result_stall,
	input ebmc_pkg::result_t result
);

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	// Show no selection and no adjusting while asleep
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.display_active |->
			result.selection == ebmc_pkg::SEL_NONE && !result.adjusting)
		else $error("selection shown while asleep");

	// Issue at most one setpoint or mode change per transaction, only when adjusting
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot0({result.temp_write, result.hum_write, result.lux_write,
			result.mode_event != ebmc_pkg::MODE_EV_NONE}) &&
			(!(result.temp_write || result.hum_write || result.lux_write ||
				result.mode_event != ebmc_pkg::MODE_EV_NONE) || result.adjusting))
		else $error("more than one change in a transaction");

	// Keep value fields at zero without their write flag
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.temp_write || result.temp_value == 8'd0) &&
			(result.hum_write || result.hum_value == 7'd0) &&
			(result.lux_write || result.lux_value == 16'd0))
		else $error("value field set without write flag");

endmodule

bind encoder_button_menu_controller ebmc_checker u_ebmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire
